// ===== rtl/core/bgi_pkg.sv =====
// ----------------------------------------------------------------------------
// bgi_pkg
// Shared types and constants of the bilinear grid interpolator: default
// sizes, register codes and reset values, channel words, control groups.
// ----------------------------------------------------------------------------
package bgi_pkg;

    localparam int MAX_ROWS_DEF    = 64;
    localparam int MAX_COLS_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int COUNT_W     = 7;

    localparam logic [COUNT_W-1:0] GRID_ROWS_RST    = 7'd64;
    localparam logic [COUNT_W-1:0] GRID_COLS_RST    = 7'd64;
    localparam logic [31:0]        X_ORIGIN_RST     = 32'd0;
    localparam logic [31:0]        Y_ORIGIN_RST     = 32'd0;
    localparam logic [31:0]        X_STEP_RECIP_RST = 32'd65536;
    localparam logic [31:0]        Y_STEP_RECIP_RST = 32'd65536;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GRID_ROWS    = 3'd0,
        CFG_GRID_COLS    = 3'd1,
        CFG_X_ORIGIN     = 3'd2,
        CFG_Y_ORIGIN     = 3'd3,
        CFG_X_STEP_RECIP = 3'd4,
        CFG_Y_STEP_RECIP = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_QUERY = 1'b1
    } req_kind_t;

    typedef struct packed {
        req_kind_t          req_type;
        logic [5:0]         row_index;
        logic [5:0]         col_index;
        logic signed [31:0] sample_value;
        logic signed [31:0] query_x;
        logic signed [31:0] query_y;
        logic               last_point;
    } req_word_t;

    typedef struct packed {
        logic signed [31:0] interp_value;
        logic               last_point_out;
    } rsp_word_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } map_en_t;

    typedef struct packed {
        logic s5;
        logic s6;
        logic s7;
    } blend_en_t;

    typedef struct packed {
        logic ipar;
        logic jpar;
        logic rv0;
        logic rv1;
        logic cv0;
        logic cv1;
    } corner_ctl_t;

endpackage

// ===== rtl/core/bgi_stream_if.sv =====
// ----------------------------------------------------------------------------
// bgi_stream_if
// Valid/ready channel carrying one word per accepted transfer.
// ----------------------------------------------------------------------------
interface bgi_stream_if #(
    parameter type word_t = logic
);

    logic  valid;
    logic  ready;
    word_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

// ===== rtl/core/bilinear_grid_interpolator.sv =====
// ----------------------------------------------------------------------------
// bilinear_grid_interpolator
// Bilinear interpolation over a uniform grid of fixed-point samples held in
// four parity-banked RAMs, one write or query word per cycle while rsp flows.
//
// The block takes one word per clock cycle, writes and queries mixed in any
// order, and keeps taking words while a result waits on rsp until the stages
// behind it fill. A query passes through registered steps in this order: the
// origin offset and the 32x32 reciprocal multiply map the point, a split
// gives cell and fraction, the corner read fetches the four corners, which
// always fall in the four row/column parity banks so that each bank sees one
// read per query, the x weighting and then the y weighting are applied, and
// a last step saturates. A write lands in its bank at the corner-read stage,
// so any later query sees it. Write words return nothing. The grid is not
// cleared at reset: a sample that was never written reads as undefined.
// ----------------------------------------------------------------------------
module bilinear_grid_interpolator #(
    parameter int MAX_ROWS    = bgi_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS    = bgi_pkg::MAX_COLS_DEF,
    parameter int VALUE_WIDTH = bgi_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = bgi_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    bgi_stream_if.sink                        req,
    bgi_stream_if.source                      rsp,
    input  logic                              cfg_we,
    input  logic [bgi_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bgi_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import bgi_pkg::*;

    localparam int CELL_W = 66 - 2 * FRAC_BITS;
    localparam int RCW    = $clog2(MAX_ROWS + 1);
    localparam int CCW    = $clog2(MAX_COLS + 1);
    localparam int HRW_C  = $clog2((MAX_ROWS + 1) / 2);
    localparam int HCW_C  = $clog2((MAX_COLS + 1) / 2);
    localparam int HRW    = (HRW_C < 1) ? 1 : HRW_C;
    localparam int HCW    = (HCW_C < 1) ? 1 : HCW_C;
    localparam int AW     = HRW + HCW;
    localparam int BANK_DEPTH = 1 << AW;

    logic [COUNT_W-1:0] grid_rows_reg;
    logic [COUNT_W-1:0] grid_cols_reg;
    logic signed [31:0] x_origin_reg;
    logic signed [31:0] y_origin_reg;
    logic [31:0]        x_step_recip_reg;
    logic [31:0]        y_step_recip_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic v1_next, v2_next, v3_next, v4_next, v5_next, v6_next, v7_next;
    logic free1, free2, free3, free4, free5, free6, free7;
    logic ld1, ld2, ld3, ld4, ld5, ld6, ld7, wr_go;

    req_kind_t          kind1_reg, kind2_reg, kind3_reg;
    logic [5:0]         row1_reg, row2_reg, row3_reg;
    logic [5:0]         col1_reg, col2_reg, col3_reg;
    logic signed [31:0] smp1_reg, smp2_reg, smp3_reg;
    logic               last1_reg, last2_reg, last3_reg, last4_reg;
    logic               last5_reg, last6_reg, last7_reg;

    map_en_t                  map_en;
    blend_en_t                blend_en;
    logic signed [CELL_W-1:0] cell_x, cell_y, cell_x1, cell_y1;
    logic [FRAC_BITS-1:0]     frac_x, frac_y;
    logic [FRAC_BITS-1:0]     frac_a4_reg, frac_b4_reg;
    logic [RCW-1:0]           rows_eff;
    logic [CCW-1:0]           cols_eff;
    logic signed [CELL_W-1:0] rows_s, cols_s;
    corner_ctl_t              ctl_next, ctl4_reg;

    logic [HRW-1:0]         row_even, row_odd;
    logic [HCW-1:0]         col_even, col_odd;
    logic                   wr_ok;
    logic [1:0]             wr_bank;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic [AW-1:0]          rd_addr [4];
    logic                   bank_we [4];
    logic [VALUE_WIDTH-1:0] rd_data [4];
    logic signed [31:0]     interp_value;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg    <= GRID_ROWS_RST;
            grid_cols_reg    <= GRID_COLS_RST;
            x_origin_reg     <= X_ORIGIN_RST;
            y_origin_reg     <= Y_ORIGIN_RST;
            x_step_recip_reg <= X_STEP_RECIP_RST;
            y_step_recip_reg <= Y_STEP_RECIP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_GRID_ROWS:    grid_rows_reg    <= cfg_data[COUNT_W-1:0];
                CFG_GRID_COLS:    grid_cols_reg    <= cfg_data[COUNT_W-1:0];
                CFG_X_ORIGIN:     x_origin_reg     <= cfg_data;
                CFG_Y_ORIGIN:     y_origin_reg     <= cfg_data;
                CFG_X_STEP_RECIP: x_step_recip_reg <= cfg_data;
                CFG_Y_STEP_RECIP: y_step_recip_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // pipeline flow: a stage is free when empty or when its word moves on
    always_comb
    begin
        free7 = !v7_reg || rsp.ready;
        free6 = !v6_reg || free7;
        free5 = !v5_reg || free6;
        free4 = !v4_reg || free5;
        free3 = !v3_reg || (kind3_reg == REQ_WRITE) || free4;
        free2 = !v2_reg || free3;
        free1 = !v1_reg || free2;

        ld1   = req.valid && free1;
        ld2   = v1_reg && free2;
        ld3   = v2_reg && free3;
        ld4   = v3_reg && (kind3_reg == REQ_QUERY) && free4;
        wr_go = v3_reg && (kind3_reg == REQ_WRITE);
        ld5   = v4_reg && free5;
        ld6   = v5_reg && free6;
        ld7   = v6_reg && free7;

        v1_next = ld1 || (v1_reg && !ld2);
        v2_next = ld2 || (v2_reg && !ld3);
        v3_next = ld3 || (v3_reg && !(ld4 || wr_go));
        v4_next = ld4 || (v4_reg && !ld5);
        v5_next = ld5 || (v5_reg && !ld6);
        v6_next = ld6 || (v6_reg && !ld7);
        v7_next = ld7 || (v7_reg && !rsp.ready);

        map_en.s1   = ld1;
        map_en.s2   = ld2;
        map_en.s3   = ld3;
        blend_en.s5 = ld5;
        blend_en.s6 = ld6;
        blend_en.s7 = ld7;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
            v5_reg <= v5_next;
            v6_reg <= v6_next;
            v7_reg <= v7_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            kind1_reg <= req.payload.req_type;
            row1_reg  <= req.payload.row_index;
            col1_reg  <= req.payload.col_index;
            smp1_reg  <= req.payload.sample_value;
            last1_reg <= req.payload.last_point;
        end
        if (ld2)
        begin
            kind2_reg <= kind1_reg;
            row2_reg  <= row1_reg;
            col2_reg  <= col1_reg;
            smp2_reg  <= smp1_reg;
            last2_reg <= last1_reg;
        end
        if (ld3)
        begin
            kind3_reg <= kind2_reg;
            row3_reg  <= row2_reg;
            col3_reg  <= col2_reg;
            smp3_reg  <= smp2_reg;
            last3_reg <= last2_reg;
        end
        if (ld4)
        begin
            last4_reg   <= last3_reg;
            ctl4_reg    <= ctl_next;
            frac_a4_reg <= frac_x;
            frac_b4_reg <= frac_y;
        end
        if (ld5)
        begin
            last5_reg <= last4_reg;
        end
        if (ld6)
        begin
            last6_reg <= last5_reg;
        end
        if (ld7)
        begin
            last7_reg <= last6_reg;
        end
    end

    bgi_axis_map #(
        .FRAC_BITS (FRAC_BITS)
    ) u_map_x (
        .clk      (clk),
        .en       (map_en),
        .coord    (req.payload.query_x),
        .origin   (x_origin_reg),
        .recip    (x_step_recip_reg),
        .cell_idx (cell_x),
        .frac     (frac_x)
    );

    bgi_axis_map #(
        .FRAC_BITS (FRAC_BITS)
    ) u_map_y (
        .clk      (clk),
        .en       (map_en),
        .coord    (req.payload.query_y),
        .origin   (y_origin_reg),
        .recip    (y_step_recip_reg),
        .cell_idx (cell_y),
        .frac     (frac_y)
    );

    // corner bounds and bank addresses
    always_comb
    begin
        rows_eff = (32'(grid_rows_reg) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(grid_rows_reg);
        cols_eff = (32'(grid_cols_reg) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(grid_cols_reg);
        rows_s   = $signed({{(CELL_W-RCW){1'b0}}, rows_eff});
        cols_s   = $signed({{(CELL_W-CCW){1'b0}}, cols_eff});
        cell_x1  = cell_x + $signed(CELL_W'(1));
        cell_y1  = cell_y + $signed(CELL_W'(1));

        ctl_next.ipar = cell_x[0];
        ctl_next.jpar = cell_y[0];
        ctl_next.rv0  = !cell_x[CELL_W-1] && (cell_x < rows_s);
        ctl_next.rv1  = !cell_x1[CELL_W-1] && (cell_x1 < rows_s);
        ctl_next.cv0  = !cell_y[CELL_W-1] && (cell_y < cols_s);
        ctl_next.cv1  = !cell_y1[CELL_W-1] && (cell_y1 < cols_s);

        row_even = cell_x1[HRW:1];
        row_odd  = cell_x[HRW:1];
        col_even = cell_y1[HCW:1];
        col_odd  = cell_y[HCW:1];

        wr_ok   = (32'(row3_reg) < MAX_ROWS) && (32'(col3_reg) < MAX_COLS);
        wr_bank = {row3_reg[0], col3_reg[0]};
        wr_addr = {HRW'(row3_reg[5:1]), HCW'(col3_reg[5:1])};
        wr_data = VALUE_WIDTH'(smp3_reg);
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_bank
        localparam int RP = k / 2;
        localparam int CP = k % 2;

        always_comb
        begin
            rd_addr[k] = {(RP == 1) ? row_odd : row_even, (CP == 1) ? col_odd : col_even};
            bank_we[k] = wr_go && wr_ok && (wr_bank == 2'(k));
        end

        bgi_ram #(
            .WIDTH (VALUE_WIDTH),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .clk   (clk),
            .we    (bank_we[k]),
            .waddr (wr_addr),
            .wdata (wr_data),
            .re    (ld4),
            .raddr (rd_addr[k]),
            .rdata (rd_data[k])
        );
    end

    bgi_blend #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_blend (
        .clk          (clk),
        .en           (blend_en),
        .ctl          (ctl4_reg),
        .bank_data    (rd_data),
        .frac_a       (frac_a4_reg),
        .frac_b       (frac_b4_reg),
        .interp_value (interp_value)
    );

    assign req.ready                  = free1;
    assign rsp.valid                  = v7_reg;
    assign rsp.payload.interp_value   = interp_value;
    assign rsp.payload.last_point_out = last7_reg;

    // a write word never opens a result slot
    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && (kind3_reg == REQ_WRITE)) |=> (!v4_reg || $past(v4_reg)))
        else $error("write word entered the corner stage");

    // hold the weighting stage while the result waits
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v6_reg && v7_reg && !rsp.ready) |=> (v6_reg && v7_reg))
        else $error("word lost behind a stalled result");

    // an accepted query enters the map stage
    a_query_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req.payload.req_type == REQ_QUERY))
        |=> (v1_reg && (kind1_reg == REQ_QUERY)))
        else $error("accepted query not captured");

    // corner read and bank write never share a cycle
    a_rw_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        ld4 |-> !(bank_we[0] || bank_we[1] || bank_we[2] || bank_we[3]))
        else $error("corner read overlaps a grid write");

endmodule

// ===== rtl/core/bgi_ram.sv =====
// ----------------------------------------------------------------------------
// bgi_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds while the read enable is low.
// ----------------------------------------------------------------------------
module bgi_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/bgi_axis_map.sv =====
// ----------------------------------------------------------------------------
// bgi_axis_map
// Three-stage map of one coordinate to grid units: offset from the origin,
// scale by the reciprocal spacing, split into a floor cell and a fraction.
// ----------------------------------------------------------------------------
module bgi_axis_map #(
    parameter  int FRAC_BITS = bgi_pkg::FRAC_BITS_DEF,
    localparam int CELL_W    = 66 - 2 * FRAC_BITS
) (
    input  logic                  clk,
    input  bgi_pkg::map_en_t      en,
    input  logic signed [31:0]    coord,
    input  logic signed [31:0]    origin,
    input  logic [31:0]           recip,
    output logic signed [CELL_W-1:0] cell_idx,
    output logic [FRAC_BITS-1:0]  frac
);

    import bgi_pkg::*;

    logic [32:0]              diff;
    logic [31:0]              abs_val;
    logic                     neg1_reg;
    logic [31:0]              abs1_reg;
    logic                     neg2_reg;
    logic [63:0]              mag2_reg;
    logic [64:0]              rnd;
    logic [64-FRAC_BITS:0]    c_val;
    logic [FRAC_BITS-1:0]     c_low;
    logic [64-2*FRAC_BITS:0]  c_high;
    logic [64-2*FRAC_BITS:0]  m_val;
    logic signed [CELL_W-1:0] cell_next;
    logic [FRAC_BITS-1:0]     frac_next;
    logic signed [CELL_W-1:0] cell_reg;
    logic [FRAC_BITS-1:0]     frac_reg;

    always_comb
    begin
        diff    = {coord[31], coord} - {origin[31], origin};
        abs_val = diff[32] ? (~diff[31:0] + 32'd1) : diff[31:0];
    end

    always_comb
    begin
        rnd    = {1'b0, mag2_reg} + 65'((64'd1 << FRAC_BITS) - 64'd1);
        c_val  = rnd[64:FRAC_BITS];
        c_low  = c_val[FRAC_BITS-1:0];
        c_high = c_val[64-FRAC_BITS:FRAC_BITS];
        m_val  = c_high + {{(64-2*FRAC_BITS){1'b0}}, |c_low};
        if (neg2_reg)
        begin
            cell_next = -$signed({1'b0, m_val});
            frac_next = -c_low;
        end
        else
        begin
            cell_next = $signed({2'b00, mag2_reg[63:2*FRAC_BITS]});
            frac_next = mag2_reg[2*FRAC_BITS-1:FRAC_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            neg1_reg <= diff[32];
            abs1_reg <= abs_val;
        end
        if (en.s2)
        begin
            neg2_reg <= neg1_reg;
            mag2_reg <= abs1_reg * recip;
        end
        if (en.s3)
        begin
            cell_reg <= cell_next;
            frac_reg <= frac_next;
        end
    end

    assign cell_idx = cell_reg;
    assign frac     = frac_reg;

endmodule

// ===== rtl/core/bgi_blend.sv =====
// ----------------------------------------------------------------------------
// bgi_blend
// Corner selection from the parity banks, weighting along x, weighting
// along y, floor to the output fraction and saturation to 32 bits.
// ----------------------------------------------------------------------------
module bgi_blend #(
    parameter int VALUE_WIDTH = bgi_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = bgi_pkg::FRAC_BITS_DEF
) (
    input  logic                    clk,
    input  bgi_pkg::blend_en_t      en,
    input  bgi_pkg::corner_ctl_t    ctl,
    input  logic [VALUE_WIDTH-1:0]  bank_data [4],
    input  logic [FRAC_BITS-1:0]    frac_a,
    input  logic [FRAC_BITS-1:0]    frac_b,
    output logic signed [31:0]      interp_value
);

    import bgi_pkg::*;

    localparam int TW = VALUE_WIDTH + FRAC_BITS + 2;
    localparam int UW = TW + FRAC_BITS + 2;
    localparam int RW = UW - 2 * FRAC_BITS;
    localparam int SW = (RW > 33) ? RW : 33;
    localparam logic signed [SW-1:0] SAT_MAX = SW'(64'sh7FFF_FFFF);
    localparam logic signed [SW-1:0] SAT_MIN = ~SAT_MAX;

    logic signed [VALUE_WIDTH-1:0] s00, s10, s01, s11;
    logic [FRAC_BITS:0]            am, bm;
    logic signed [FRAC_BITS+1:0]   a_s, am_s, b_s, bm_s;
    logic signed [TW-1:0]          t0_reg, t1_reg;
    logic signed [FRAC_BITS+1:0]   b5_reg, bm5_reg;
    logic signed [UW-1:0]          u_reg;
    logic signed [RW-1:0]          r_val;
    logic signed [SW-1:0]          r_ext;
    logic signed [31:0]            value_next;
    logic signed [31:0]            value_reg;

    always_comb
    begin
        s00 = (ctl.rv0 && ctl.cv0) ? $signed(bank_data[{ctl.ipar, ctl.jpar}]) : '0;
        s10 = (ctl.rv1 && ctl.cv0) ? $signed(bank_data[{~ctl.ipar, ctl.jpar}]) : '0;
        s01 = (ctl.rv0 && ctl.cv1) ? $signed(bank_data[{ctl.ipar, ~ctl.jpar}]) : '0;
        s11 = (ctl.rv1 && ctl.cv1) ? $signed(bank_data[{~ctl.ipar, ~ctl.jpar}]) : '0;
        am   = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac_a};
        bm   = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac_b};
        a_s  = $signed({2'b00, frac_a});
        am_s = $signed({1'b0, am});
        b_s  = $signed({2'b00, frac_b});
        bm_s = $signed({1'b0, bm});
    end

    always_comb
    begin
        r_val = $signed(u_reg[UW-1:2*FRAC_BITS]);
        r_ext = SW'(r_val);
        priority if (r_ext > SAT_MAX)
        begin
            value_next = 32'sh7FFF_FFFF;
        end
        else if (r_ext < SAT_MIN)
        begin
            value_next = 32'sh8000_0000;
        end
        else
        begin
            value_next = r_ext[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s5)
        begin
            t0_reg  <= TW'(s00) * TW'(am_s) + TW'(s10) * TW'(a_s);
            t1_reg  <= TW'(s01) * TW'(am_s) + TW'(s11) * TW'(a_s);
            b5_reg  <= b_s;
            bm5_reg <= bm_s;
        end
        if (en.s6)
        begin
            u_reg <= UW'(t0_reg) * UW'(bm5_reg) + UW'(t1_reg) * UW'(b5_reg);
        end
        if (en.s7)
        begin
            value_reg <= value_next;
        end
    end

    assign interp_value = value_reg;

endmodule
